// ===== hw/rtl/msp_pkg.sv =====
// ----------------------------------------------------------------------------
// msp_pkg
// Shared field widths, register codes, battery window bounds and the
// per-stage advance strobes of the motor speed PI tick block.
// ----------------------------------------------------------------------------
package msp_pkg;

  // item field widths
  localparam int unsigned ENC_W      = 16;
  localparam int unsigned BATT_W     = 14;
  localparam int unsigned MAG_W      = 13;

  // configuration register widths
  localparam int unsigned GAIN_W     = 10;
  localparam int unsigned SPEED_W    = 13;
  localparam int unsigned LIMIT_W    = 13;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  // speed error: target minus encoder delta
  localparam int unsigned ERR_W      = 18;

  // accumulator clamp in whole drive units, and gain scale
  localparam int unsigned ACC_LIMIT  = 7199;
  localparam int unsigned PI_SCALE   = 100;

  // register reset values
  localparam logic [GAIN_W-1:0]         GAIN_P_RST       = GAIN_W'(30);
  localparam logic [GAIN_W-1:0]         GAIN_I_RST       = GAIN_W'(200);
  localparam logic signed [SPEED_W-1:0] TARGET_SPEED_RST = SPEED_W'(20);
  localparam logic [LIMIT_W-1:0]        DRIVE_LIMIT_RST  = LIMIT_W'(7100);

  // cutoff windows, bounds exclusive
  localparam logic [BATT_W-1:0] CUT_A_LO = BATT_W'(600);
  localparam logic [BATT_W-1:0] CUT_A_HI = BATT_W'(720);
  localparam logic [BATT_W-1:0] CUT_B_LO = BATT_W'(1000);
  localparam logic [BATT_W-1:0] CUT_B_HI = BATT_W'(1120);
  localparam logic [BATT_W-1:0] CUT_C_LO = BATT_W'(2100);
  localparam logic [BATT_W-1:0] CUT_C_HI = BATT_W'(2230);

  // warning bands, bounds exclusive, same lower bounds as the cutoff
  localparam logic [BATT_W-1:0] WARN_A_HI = BATT_W'(760);
  localparam logic [BATT_W-1:0] WARN_B_HI = BATT_W'(1130);
  localparam logic [BATT_W-1:0] WARN_C_HI = BATT_W'(2250);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P       = 2'd0,
    CFG_GAIN_I       = 2'd1,
    CFG_TARGET_SPEED = 2'd2,
    CFG_DRIVE_LIMIT  = 2'd3
  } cfg_idx_e;

  // one strobe per pipeline register after the input register: an item moves into that stage
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
    logic so;
  } adv_t;

endpackage

// ===== hw/rtl/msp_scale_div.sv =====
// ----------------------------------------------------------------------------
// msp_scale_div
// Two-stage signed scaling y = trunc(x * 2^FracBits / 100), exact, rounded
// toward zero: reciprocal multiply for x / 100, then a remainder table.
// ----------------------------------------------------------------------------
module msp_scale_div #(
  parameter int unsigned XW       = 30,
  parameter int unsigned FracBits = 8
) (
  input  logic                      clk_i,
  input  msp_pkg::adv_t             adv_i,
  input  logic signed [XW-1:0]      x_i,
  output logic signed [XW-7+FracBits:0] y_o
);

  localparam int unsigned NW     = XW - 1;
  localparam int unsigned QW     = NW - 6;
  localparam int unsigned MagW   = QW + FracBits;
  localparam int unsigned RecipK = NW + 7;
  localparam int unsigned RecipW = NW + 1;
  localparam int unsigned ProdW  = NW + RecipW;
  localparam longint unsigned RecipM =
    ((64'd1 << RecipK) + msp_pkg::PI_SCALE - 1) / msp_pkg::PI_SCALE;
  localparam int unsigned FracW  = (FracBits > 0) ? FracBits : 1;
  localparam int unsigned TabN   = 128;

  // floor(r * 2^FracBits / 100) for each remainder r
  function automatic logic [TabN*FracW-1:0] frac_table();
    logic [TabN*FracW-1:0] tab;
    tab = '0;
    for (int i = 0; i < TabN; i++) begin
      tab[i*FracW +: FracW] = FracW'((i * (2 ** FracBits)) / msp_pkg::PI_SCALE);
    end
    return tab;
  endfunction

  localparam logic [TabN*FracW-1:0] FracTab = frac_table();

  logic signed [XW-1:0] x_abs;
  logic [NW-1:0]        n;
  logic [ProdW-1:0]     prod;
  logic [QW-1:0]        q_d, q_q;
  logic [6:0]           n_low_q;
  logic                 neg_q;

  logic [QW-1:0]        q100;
  logic [6:0]           rem;
  logic [FracW-1:0]     frac;
  logic [MagW-1:0]      mag_hi, mag;
  logic signed [MagW:0] y_d;

  // stage a: magnitude and quotient by 100
  always_comb begin
    x_abs = x_i[XW-1] ? -x_i : x_i;
    n     = x_abs[NW-1:0];
    prod  = ProdW'(n) * ProdW'(RecipM);
    q_d   = prod[RecipK +: QW];
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s3) begin
      q_q     <= q_d;
      n_low_q <= n[6:0];
      neg_q   <= x_i[XW-1];
    end
  end

  // stage b: remainder below 100 only needs the low seven bits
  always_comb begin
    q100   = q_q * QW'(msp_pkg::PI_SCALE);
    rem    = n_low_q - q100[6:0];
    frac   = FracTab[rem*FracW +: FracW];
    mag_hi = MagW'(q_q);
    mag    = (mag_hi << FracBits) + MagW'(frac);
    y_d    = neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s4) begin
      y_o <= y_d;
    end
  end

endmodule

// ===== hw/rtl/msp_batt.sv =====
// ----------------------------------------------------------------------------
// msp_batt
// Battery block averaging: running sum and count, reciprocal divide on the
// completed block, then the average register and its window tests.
// ----------------------------------------------------------------------------
module msp_batt #(
  parameter int unsigned SamplesPerAverage = 100
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  msp_pkg::adv_t               adv_i,
  input  logic [msp_pkg::BATT_W-1:0]  sample_i,
  output logic                        low_win_o,
  output logic                        warn_o,
  output logic [msp_pkg::BATT_W-1:0]  average_o
);

  localparam int unsigned BW     = msp_pkg::BATT_W;
  localparam int unsigned SumW   = $clog2(SamplesPerAverage * ((2 ** BW) - 1) + 1);
  localparam int unsigned CntW   = $clog2(SamplesPerAverage + 1);
  localparam int unsigned ShiftL = $clog2(SamplesPerAverage);
  localparam int unsigned RecipK = SumW + ShiftL;
  localparam int unsigned RecipW = SumW + 2;
  localparam int unsigned ProdW  = SumW + RecipW;
  localparam longint unsigned RecipM =
    ((64'd1 << RecipK) + SamplesPerAverage - 1) / SamplesPerAverage;

  logic [SumW-1:0]  sum_q, sum_d, sum_full, bsum_q;
  logic [CntW-1:0]  cnt_q, cnt_d, cnt_full;
  logic             wrap, wrap2_q, wrap3_q;
  logic [ProdW-1:0] prod;
  logic [BW-1:0]    quot_q;
  logic [BW-1:0]    avg_q, avg_d;
  logic             low_win_d, warn_d;

  // stage 2: accumulate, close the block after the last sample
  always_comb begin
    sum_full = sum_q + SumW'(sample_i);
    cnt_full = cnt_q + CntW'(1);
    wrap     = (cnt_full == CntW'(SamplesPerAverage));
    sum_d    = wrap ? '0 : sum_full;
    cnt_d    = wrap ? '0 : cnt_full;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else if (adv_i.s2) begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s2) begin
      bsum_q  <= sum_full;
      wrap2_q <= wrap;
    end
  end

  // stage 3: block sum divided by the sample count
  assign prod = ProdW'(bsum_q) * ProdW'(RecipM);

  always_ff @(posedge clk_i) begin
    if (adv_i.s3) begin
      quot_q  <= prod[RecipK +: BW];
      wrap3_q <= wrap2_q;
    end
  end

  // stage 4: average register and window tests on the new value
  always_comb begin
    avg_d = wrap3_q ? quot_q : avg_q;
    low_win_d = (avg_d > msp_pkg::CUT_A_LO && avg_d < msp_pkg::CUT_A_HI) ||
                (avg_d > msp_pkg::CUT_B_LO && avg_d < msp_pkg::CUT_B_HI) ||
                (avg_d > msp_pkg::CUT_C_LO && avg_d < msp_pkg::CUT_C_HI);
    warn_d    = (avg_d > msp_pkg::CUT_A_LO && avg_d < msp_pkg::WARN_A_HI) ||
                (avg_d > msp_pkg::CUT_B_LO && avg_d < msp_pkg::WARN_B_HI) ||
                (avg_d > msp_pkg::CUT_C_LO && avg_d < msp_pkg::WARN_C_HI);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q <= '0;
    end else if (adv_i.s4) begin
      avg_q <= avg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s4) begin
      low_win_o <= low_win_d;
      warn_o    <= warn_d;
    end
  end

  assign average_o = avg_q;

endmodule

// ===== hw/rtl/msp_pi_loop.sv =====
// ----------------------------------------------------------------------------
// msp_pi_loop
// Per-tick state loop: drive accumulator with clamp, previous-error flag,
// low-voltage tick counter and the run flag.
// ----------------------------------------------------------------------------
module msp_pi_loop #(
  parameter int unsigned AccMax        = 1842944,
  parameter int unsigned IncW          = 33,
  parameter int unsigned ShutdownTicks = 500
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  msp_pkg::adv_t                     adv_i,
  input  logic signed [IncW-1:0]            inc_diff_i,
  input  logic signed [IncW-1:0]            inc_full_i,
  input  logic                              click_i,
  input  logic                              low_win_i,
  output logic signed [$clog2(AccMax+1):0]  acc_o,
  output logic                              was_running_o,
  output logic                              running_o
);

  localparam int unsigned AccW = $clog2(AccMax + 1) + 1;
  localparam int unsigned SumW = ((IncW > AccW) ? IncW : AccW) + 1;
  localparam int unsigned LtW  = $clog2(ShutdownTicks + 2);
  localparam logic signed [SumW-1:0] AccMaxS = SumW'(AccMax);

  logic signed [AccW-1:0] acc_q, acc_d;
  logic signed [IncW-1:0] inc;
  logic signed [SumW-1:0] sum, sat;
  logic                   err_valid_q;
  logic                   run_q, run_d;
  logic [LtW-1:0]         low_q, low_d;
  logic                   cutoff;

  always_comb begin
    // previous error is the last item's error only if that item ran
    inc = err_valid_q ? inc_diff_i : inc_full_i;
    sum = SumW'(acc_q) + SumW'(inc);
    if (sum > AccMaxS) begin
      sat = AccMaxS;
    end else if (sum < -AccMaxS) begin
      sat = -AccMaxS;
    end else begin
      sat = sum;
    end
    acc_d = run_q ? sat[AccW-1:0] : '0;

    if (!low_win_i) begin
      low_d = '0;
    end else if (low_q <= LtW'(ShutdownTicks)) begin
      low_d = low_q + LtW'(1);
    end else begin
      low_d = low_q;
    end
    cutoff = (low_d > LtW'(ShutdownTicks));
    run_d  = (run_q ^ click_i) & ~cutoff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      err_valid_q <= 1'b0;
      run_q       <= 1'b0;
      low_q       <= '0;
    end else if (adv_i.s6) begin
      acc_q       <= acc_d;
      err_valid_q <= run_q;
      run_q       <= run_d;
      low_q       <= low_d;
    end
  end

  assign acc_o         = acc_q;
  assign was_running_o = err_valid_q;
  assign running_o     = run_q;

endmodule

// ===== hw/rtl/motor_speed_pi_tick.sv =====
// ----------------------------------------------------------------------------
// motor_speed_pi_tick
// Motor speed control tick: one item per control tick carries an encoder
// count delta, a battery sample and a start click; one result item comes
// back with the bridge drive (magnitude and direction bits), the run flag,
// the battery warning flag and the latest battery block average. An
// incremental PI controller works on a drive accumulator with FracBits
// fractional bits, clamped to +-7199 and zeroed while stopped; the drive is
// truncated toward zero and limited to +-drive_limit. A click toggles run,
// and more than ShutdownTicks ticks in a low-voltage window stop the motor.
// Rate: one item per clock while the output is not stalled. The pipeline
// is input register, error and gain products, divide-by-100 reciprocal
// multiply, remainder and sign, increment sum, the state loop (accumulator,
// run flag, low-voltage count) and the result register. Each stage holds
// while the one after it is full and stalled, so bubbles close up and
// items still enter while a result waits.
// Config writes are always taken (ready is tied high) and must only happen
// while the block is idle.
// ----------------------------------------------------------------------------
module motor_speed_pi_tick #(
  parameter int unsigned SamplesPerAverage = 100,
  parameter int unsigned ShutdownTicks     = 500,
  parameter int unsigned FracBits          = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input items
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [msp_pkg::ENC_W-1:0]    encoder_delta_i,
  input  logic [msp_pkg::BATT_W-1:0]          battery_sample_i,
  input  logic                                start_click_i,
  // result items
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [msp_pkg::MAG_W-1:0]           drive_magnitude_o,
  output logic                                bridge_in1_o,
  output logic                                bridge_in2_o,
  output logic                                running_o,
  output logic                                battery_low_warn_o,
  output logic [msp_pkg::BATT_W-1:0]          battery_average_o,
  // register writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [msp_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [msp_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned PipeDepth = 7;
  localparam int unsigned ErrW      = msp_pkg::ERR_W;
  // gain (zero extended) times error difference
  localparam int unsigned ProdW     = msp_pkg::GAIN_W + 1 + ErrW + 1;
  localparam int unsigned TermW     = ProdW - 6 + FracBits;
  localparam int unsigned IncW      = TermW + 1;
  localparam int unsigned AccMax    = msp_pkg::ACC_LIMIT * (2 ** FracBits);
  localparam int unsigned AccW      = $clog2(AccMax + 1) + 1;
  localparam int unsigned DrvW      = AccW - FracBits;
  localparam int unsigned CmpW      =
    ((DrvW > msp_pkg::LIMIT_W + 1) ? DrvW : msp_pkg::LIMIT_W + 1) + 1;
  localparam logic signed [AccW-1:0] RoundBias = AccW'((2 ** FracBits) - 1);

  // ---------------------------------------------------------------- config
  logic [msp_pkg::GAIN_W-1:0]         gain_p_q, gain_i_q;
  logic signed [msp_pkg::SPEED_W-1:0] target_speed_q;
  logic [msp_pkg::LIMIT_W-1:0]        drive_limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q       <= msp_pkg::GAIN_P_RST;
      gain_i_q       <= msp_pkg::GAIN_I_RST;
      target_speed_q <= msp_pkg::TARGET_SPEED_RST;
      drive_limit_q  <= msp_pkg::DRIVE_LIMIT_RST;
    end else if (cfg_valid_i) begin
      case (msp_pkg::cfg_idx_e'(cfg_index_i))
        msp_pkg::CFG_GAIN_P:       gain_p_q       <= cfg_data_i[msp_pkg::GAIN_W-1:0];
        msp_pkg::CFG_GAIN_I:       gain_i_q       <= cfg_data_i[msp_pkg::GAIN_W-1:0];
        msp_pkg::CFG_TARGET_SPEED: target_speed_q <= cfg_data_i[msp_pkg::SPEED_W-1:0];
        msp_pkg::CFG_DRIVE_LIMIT:  drive_limit_q  <= cfg_data_i[msp_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------ pipeline control
  // vld_q[0] is the input register, vld_q[PipeDepth-1] the result register
  logic [PipeDepth-1:0] vld_q, vld_d, ld;
  msp_pkg::adv_t        adv;
  logic                 in_accept;

  always_comb begin
    ld[PipeDepth-1] = !vld_q[PipeDepth-1] || !out_stall_i;
    for (int k = PipeDepth - 2; k >= 0; k--) begin
      ld[k] = !vld_q[k] || ld[k+1];
    end
    vld_d[0] = ld[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < PipeDepth; k++) begin
      vld_d[k] = ld[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_comb begin
    adv.s2 = ld[1] & vld_q[0];
    adv.s3 = ld[2] & vld_q[1];
    adv.s4 = ld[3] & vld_q[2];
    adv.s5 = ld[4] & vld_q[3];
    adv.s6 = ld[5] & vld_q[4];
    adv.so = ld[6] & vld_q[5];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_accept   = in_valid_i & ld[0];
  assign in_stall_o  = !ld[0];
  assign out_valid_o = vld_q[PipeDepth-1];

  // ------------------------------------------------------ stage 1: input
  logic signed [msp_pkg::ENC_W-1:0] enc1_q;
  logic [msp_pkg::BATT_W-1:0]       samp1_q;
  logic                             click1_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      enc1_q   <= encoder_delta_i;
      samp1_q  <= battery_sample_i;
      click1_q <= start_click_i;
    end
  end

  // -------------------------------------- stage 2: error and gain products
  logic signed [ErrW-1:0]  err, last_err_q;
  logic signed [ErrW:0]    err_diff;
  logic signed [ProdW-1:0] prod_diff, prod_full, prod_int;
  logic signed [ProdW-1:0] prod_diff2_q, prod_full2_q, prod_int2_q;
  logic                    click2_q;

  always_comb begin
    err       = ErrW'(target_speed_q) - ErrW'(enc1_q);
    err_diff  = (ErrW + 1)'(err) - (ErrW + 1)'(last_err_q);
    // proportional term on the error change, or on the error alone when
    // the previous item was a stopped tick
    prod_diff = ProdW'($signed({1'b0, gain_p_q})) * ProdW'(err_diff);
    prod_full = ProdW'($signed({1'b0, gain_p_q})) * ProdW'(err);
    prod_int  = ProdW'($signed({1'b0, gain_i_q})) * ProdW'(err);
  end

  // error of the last item, whatever its run state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q <= '0;
    end else if (adv.s2) begin
      last_err_q <= err;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv.s2) begin
      prod_diff2_q <= prod_diff;
      prod_full2_q <= prod_full;
      prod_int2_q  <= prod_int;
      click2_q     <= click1_q;
    end
  end

  // ------------------------------------- stages 3 and 4: scale by 2^F/100
  logic signed [TermW-1:0] term_diff4, term_full4, term_int4;
  logic                    click3_q, click4_q;

  msp_scale_div #(
    .XW       (ProdW),
    .FracBits (FracBits)
  ) u_div_diff (
    .clk_i (clk_i),
    .adv_i (adv),
    .x_i   (prod_diff2_q),
    .y_o   (term_diff4)
  );

  msp_scale_div #(
    .XW       (ProdW),
    .FracBits (FracBits)
  ) u_div_full (
    .clk_i (clk_i),
    .adv_i (adv),
    .x_i   (prod_full2_q),
    .y_o   (term_full4)
  );

  msp_scale_div #(
    .XW       (ProdW),
    .FracBits (FracBits)
  ) u_div_int (
    .clk_i (clk_i),
    .adv_i (adv),
    .x_i   (prod_int2_q),
    .y_o   (term_int4)
  );

  always_ff @(posedge clk_i) begin
    if (adv.s3) begin
      click3_q <= click2_q;
    end
    if (adv.s4) begin
      click4_q <= click3_q;
    end
  end

  // battery path runs alongside, its results line up at stage 4
  logic                       low_win4, warn4;
  logic [msp_pkg::BATT_W-1:0] avg4;

  msp_batt #(
    .SamplesPerAverage (SamplesPerAverage)
  ) u_batt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .sample_i  (samp1_q),
    .low_win_o (low_win4),
    .warn_o    (warn4),
    .average_o (avg4)
  );

  // ---------------------------------------------- stage 5: increment sums
  logic signed [IncW-1:0]     inc_diff5_q, inc_full5_q;
  logic                       click5_q, low_win5_q, warn5_q;
  logic [msp_pkg::BATT_W-1:0] avg5_q;

  always_ff @(posedge clk_i) begin
    if (adv.s5) begin
      inc_diff5_q <= IncW'(term_diff4) + IncW'(term_int4);
      inc_full5_q <= IncW'(term_full4) + IncW'(term_int4);
      click5_q    <= click4_q;
      low_win5_q  <= low_win4;
      warn5_q     <= warn4;
      avg5_q      <= avg4;
    end
  end

  // ------------------------------------------------ stage 6: state loop
  logic signed [AccW-1:0]     acc6;
  logic                       was_running6, running6;
  logic                       warn6_q;
  logic [msp_pkg::BATT_W-1:0] avg6_q;

  msp_pi_loop #(
    .AccMax        (AccMax),
    .IncW          (IncW),
    .ShutdownTicks (ShutdownTicks)
  ) u_loop (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .inc_diff_i    (inc_diff5_q),
    .inc_full_i    (inc_full5_q),
    .click_i       (click5_q),
    .low_win_i     (low_win5_q),
    .acc_o         (acc6),
    .was_running_o (was_running6),
    .running_o     (running6)
  );

  always_ff @(posedge clk_i) begin
    if (adv.s6) begin
      warn6_q <= warn5_q;
      avg6_q  <= avg5_q;
    end
  end

  // ------------------------------------ result stage: drive and bridge bits
  logic signed [AccW-1:0] acc_biased, acc_shift;
  logic signed [DrvW-1:0] drv_trunc;
  logic signed [CmpW-1:0] drv_x, lim_x, drv_c, drv_abs;
  logic                   drv_neg;

  always_comb begin
    // truncate toward zero: bias negative values before the shift
    acc_biased = acc6[AccW-1] ? acc6 + RoundBias : acc6;
    acc_shift  = acc_biased >>> FracBits;
    drv_trunc  = acc_shift[DrvW-1:0];
    drv_x      = CmpW'(drv_trunc);
    lim_x      = CmpW'({1'b0, drive_limit_q});
    if (!was_running6) begin
      drv_c = '0;
    end else if (drv_x > lim_x) begin
      drv_c = lim_x;
    end else if (drv_x < -lim_x) begin
      drv_c = -lim_x;
    end else begin
      drv_c = drv_x;
    end
    drv_neg = drv_c[CmpW-1];
    drv_abs = drv_neg ? -drv_c : drv_c;
  end

  always_ff @(posedge clk_i) begin
    if (adv.so) begin
      drive_magnitude_o  <= drv_abs[msp_pkg::MAG_W-1:0];
      bridge_in1_o       <= !drv_neg;
      bridge_in2_o       <= drv_neg;
      running_o          <= running6;
      battery_low_warn_o <= warn6_q;
      battery_average_o  <= avg6_q;
    end
  end

endmodule
